@@ hdl/cbsd_pkg.sv @@
`timescale 1ns / 1ps
package cbsd_pkg;

  localparam int PIX_W      = 16;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int HALF_W     = 5;
  localparam int NM_W       = 16;
  localparam int CAP_W      = 25;
  localparam int CNT_W      = 6;
  localparam int SUM_W      = 22;
  localparam int PRODV_W    = PIX_W + CNT_W;
  localparam int PRODN_W    = NM_W + CNT_W + 1;
  localparam int CMP_W      = 28;
  localparam int RING_AW    = 6;
  localparam int RING_D     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int MAX_DIM    = 4096;
  localparam int MAX_HALF   = 31;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MASK = 3'd5;

  typedef struct packed {
    logic accept;
    logic setup;
    logic step;
    logic mul;
    logic decide;
    logic finish;
  } cbsd_cmd_t;

  typedef struct packed {
    logic work;
    logic k_last;
    logic d_done;
    logic hit;
    logic pend_valid;
    logic out_free;
  } cbsd_sts_t;

endpackage

@@ hdl/column_boxcar_signal_detect.sv @@
`timescale 1ns / 1ps
// one pixel at a time: accept, then per decided row a setup, a window sweep over cnt rows,
// a drain, a multiply and a compare (cnt = rows in the window, up to 2 * half_window, one
// ring read per cycle), then a finish step; a column's last pixel takes up to half_window + 1
// such sweeps; a result is held until the next hit or the pixel's finish step,
// then moves to a registered output, and a full output register can stall the compare and the finish
// rst (synchronous) restores register defaults, clears counters and marks the ring empty
module column_boxcar_signal_detect (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cbsd_pkg::PIX_W-1:0]          s_tdata,   // pixel_value
  input  logic [0:0]                          s_tuser,   // pixel_good
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*cbsd_pkg::COORD_W-1:0]      m_tdata,   // hit_row (upper), hit_column (lower)
  output logic [0:0]                          m_tuser,   // overflow
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbsd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cbsd_pkg::*;

  cbsd_cmd_t cmd;
  cbsd_sts_t sts;

  cbsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbsd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ hdl/cbsd_ctrl.sv @@
`timescale 1ns / 1ps
module cbsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  cbsd_pkg::cbsd_sts_t sts,
  output cbsd_pkg::cbsd_cmd_t cmd
);
  import cbsd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = sts.work ? S_SETUP : S_FIN;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.step = 1'b1;
        if (sts.k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        // a new hit pushes the held one out, so the output slot must be free
        if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
          cmd.decide = 1'b1;
          state_next = sts.d_done ? S_FIN : S_SETUP;
        end
      end
      S_FIN: begin
        if (!(sts.pend_valid && !sts.out_free)) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_nothing_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.pend_valid)
    else $error("held result left over between pixels");

  a_push_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && sts.hit && sts.pend_valid) |-> sts.out_free)
    else $error("result pushed into occupied output register");
`endif

endmodule

@@ hdl/cbsd_datapath.sv @@
`timescale 1ns / 1ps
module cbsd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cbsd_pkg::cbsd_cmd_t                 cmd,
  output cbsd_pkg::cbsd_sts_t                 sts,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [cbsd_pkg::PIX_W-1:0]          s_tdata,
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*cbsd_pkg::COORD_W-1:0]      m_tdata,
  output logic [0:0]                          m_tuser,
  output logic                                m_tlast
);
  import cbsd_pkg::*;

  // configuration registers
  logic [DIM_W-1:0]         columns;
  logic [DIM_W-1:0]         rows;
  logic [HALF_W-1:0]        half_window;
  logic signed [NM_W-1:0]   noise_margin;
  logic [CAP_W-1:0]         capacity;
  logic                     use_mask;

  // frame state
  logic [COORD_W-1:0]       row_counter;
  logic [COORD_W-1:0]       column_counter;
  logic [CAP_W-1:0]         found_count;
  logic                     aborted;

  // per pixel plan
  logic [COORD_W-1:0]       d;
  logic [COORD_W-1:0]       d_end;
  logic [COORD_W-1:0]       cur;
  logic                     last_row_r;

  // window sweep
  logic [COORD_W-1:0]       k;
  logic [COORD_W-1:0]       hi_r;
  logic [CNT_W-1:0]         cnt;
  logic [SUM_W-1:0]         sum;
  logic [PIX_W-1:0]         v;
  logic                     good;
  logic                     acc_q;
  logic                     cap_q;
  logic [PIX_W:0]           rd_word;
  logic                     rd_vld;

  logic [PIX_W:0]           ring [RING_D];
  logic [RING_D-1:0]        ring_vld;

  logic [PRODV_W-1:0]       prod_v;
  logic signed [PRODN_W-1:0] prod_n;

  // held result and output register
  logic                     pend_valid;
  logic [COORD_W-1:0]       pend_col;
  logic [COORD_W-1:0]       pend_row;
  logic                     pend_ovf;
  logic                     out_push;

  // effective sizes
  logic [HALF_W-1:0]        half_e;
  logic [DIM_W-1:0]         rows_e;
  logic [DIM_W-1:0]         cols_e;
  logic [COORD_W-1:0]       half_c;
  logic                     last_row;
  logic                     r_ge_half;
  logic                     last_col;

  logic [DIM_W-1:0]         d1;
  logic [DIM_W-1:0]         dh;
  logic [COORD_W-1:0]       lo;
  logic [COORD_W-1:0]       hi;
  logic [COORD_W-1:0]       span;

  logic signed [CMP_W-1:0]  lhs;
  logic signed [CMP_W-1:0]  rhs;
  logic                     hit;
  logic                     ovf_case;
  logic                     out_free;
  logic [PIX_W-1:0]         rd_v;

  assign cfg_ready = 1'b1;

  always_comb begin
    half_e = half_window;
    if (half_window == '0) begin
      half_e = HALF_W'(1);
    end else if (half_window > HALF_W'(MAX_HALF)) begin
      half_e = HALF_W'(MAX_HALF);
    end
    rows_e = rows;
    if (rows == '0) begin
      rows_e = DIM_W'(1);
    end else if (rows > DIM_W'(MAX_DIM)) begin
      rows_e = DIM_W'(MAX_DIM);
    end
    cols_e = columns;
    if (columns == '0) begin
      cols_e = DIM_W'(1);
    end else if (columns > DIM_W'(MAX_DIM)) begin
      cols_e = DIM_W'(MAX_DIM);
    end
  end

  assign half_c    = COORD_W'(half_e);
  assign last_row  = ({1'b0, row_counter} >= (rows_e - DIM_W'(1)));
  assign r_ge_half = (row_counter >= half_c);
  assign last_col  = ({1'b0, column_counter} >= (cols_e - DIM_W'(1)));

  // window bounds of row d, clipped at the top and at the newest row
  always_comb begin
    d1 = {1'b0, d} + DIM_W'(1);
    dh = {1'b0, d} + DIM_W'(half_e);
    lo = (d1 >= DIM_W'(half_e)) ? COORD_W'(d1 - DIM_W'(half_e)) : '0;
    hi = (dh < {1'b0, cur}) ? dh[COORD_W-1:0] : cur;
    span = hi - lo + COORD_W'(1);
  end

  assign rd_v = rd_vld ? rd_word[PIX_W-1:0] : '0;

  // 16*v*cnt > 16*sum + margin*cnt
  assign lhs = $signed({{(CMP_W-PRODV_W-4){1'b0}}, prod_v, 4'b0000});
  assign rhs = $signed({{(CMP_W-SUM_W-4){1'b0}}, sum, 4'b0000})
             + $signed({{(CMP_W-PRODN_W){prod_n[PRODN_W-1]}}, prod_n});
  assign hit = !aborted && (!use_mask || good) && (lhs > rhs);
  assign ovf_case = (found_count >= capacity);
  assign out_free = !m_tvalid || m_tready;
  assign out_push = pend_valid && ((cmd.decide && hit) || cmd.finish);

  assign sts.work       = last_row || r_ge_half;
  assign sts.k_last     = (k == hi_r);
  assign sts.d_done     = (d == d_end);
  assign sts.hit        = hit;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

  // ring of recent pixels
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[row_counter[RING_AW-1:0]] <= {s_tuser[0], s_tdata};
    end
    if (cmd.step) begin
      rd_word <= ring[k[RING_AW-1:0]];
      rd_vld  <= ring_vld[k[RING_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
    end else if (cmd.accept) begin
      ring_vld[row_counter[RING_AW-1:0]] <= 1'b1;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      columns      <= DIM_W'(1);
      rows         <= DIM_W'(1);
      half_window  <= HALF_W'(1);
      noise_margin <= NM_W'(16);
      capacity     <= CAP_W'(16777216);
      use_mask     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMNS:  columns      <= cfg_data[DIM_W-1:0];
        REG_ROWS:     rows         <= cfg_data[DIM_W-1:0];
        REG_HALF:     half_window  <= cfg_data[HALF_W-1:0];
        REG_MARGIN:   noise_margin <= $signed(cfg_data[NM_W-1:0]);
        REG_CAPACITY: capacity     <= cfg_data[CAP_W-1:0];
        REG_USE_MASK: use_mask     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sweep and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur        <= row_counter;
      last_row_r <= last_row;
      d          <= r_ge_half ? (row_counter - half_c) : '0;
      d_end      <= last_row ? row_counter : (row_counter - half_c);
    end
    if (cmd.setup) begin
      k    <= lo;
      hi_r <= hi;
      cnt  <= span[CNT_W-1:0];
      sum  <= '0;
    end else if (acc_q) begin
      sum <= sum + SUM_W'(rd_v);
    end
    if (cmd.step) begin
      k <= k + COORD_W'(1);
    end
    if (cap_q) begin
      v    <= rd_v;
      good <= rd_vld && rd_word[PIX_W];
    end
    if (cmd.mul) begin
      prod_v <= PRODV_W'(v) * PRODV_W'(cnt);
      prod_n <= PRODN_W'(noise_margin) * $signed({{(PRODN_W-CNT_W){1'b0}}, cnt});
    end
    if (cmd.decide) begin
      d <= d + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_q <= 1'b0;
      cap_q <= 1'b0;
    end else begin
      acc_q <= cmd.step;
      cap_q <= cmd.step && (k == d);
    end
  end

  // decisions, held result, output register, frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
      found_count    <= '0;
      aborted        <= 1'b0;
      pend_valid     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (out_push) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= {pend_row, pend_col};
        m_tuser[0] <= pend_ovf;
        m_tlast    <= cmd.finish;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.decide && hit) begin
        pend_valid <= 1'b1;
        if (ovf_case) begin
          pend_col <= '0;
          pend_row <= '0;
          pend_ovf <= 1'b1;
          aborted  <= 1'b1;
        end else begin
          pend_col    <= column_counter;
          pend_row    <= d;
          pend_ovf    <= 1'b0;
          found_count <= found_count + CAP_W'(1);
        end
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
        if (last_row_r) begin
          row_counter <= '0;
          if (last_col) begin
            column_counter <= '0;
            found_count    <= '0;
            aborted        <= 1'b0;
          end else begin
            column_counter <= column_counter + COORD_W'(1);
          end
        end else begin
          row_counter <= cur + COORD_W'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_overflow_zero_coords: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("overflow result carries coordinates");

  a_window_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> (cnt != '0))
    else $error("empty window at compare");
`endif

endmodule

@@ test/tb_column_boxcar_signal_detect.sv @@
`timescale 1ns / 1ps
module tb_column_boxcar_signal_detect;
  import cbsd_pkg::*;

  localparam int SETTLE_CYCLES  = 2600;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int CAP_TOP        = 16777216;

  typedef struct {
    bit [COORD_W-1:0] col;
    bit [COORD_W-1:0] row;
    bit               ovf;
    bit               last;
  } detection_t;

  class detect_scoreboard;
    bit [DIM_W-1:0]  columns_r;
    bit [DIM_W-1:0]  rows_r;
    bit [HALF_W-1:0] half_r;
    shortint         margin_r;
    bit [CAP_W-1:0]  cap_r;
    bit              mask_r;
    bit [PIX_W-1:0]  value_ring [RING_D];
    bit              good_ring [RING_D];
    int unsigned     row_cnt;
    int unsigned     col_cnt;
    int unsigned     found;
    bit              aborted;
    detection_t      pending_hits [$];
    int              errors;

    function new();
      columns_r = 1;
      rows_r    = 1;
      half_r    = 1;
      margin_r  = 16;
      cap_r     = CAP_W'(CAP_TOP);
      mask_r    = 0;
      foreach (value_ring[i]) begin
        value_ring[i] = '0;
        good_ring[i]  = 1'b0;
      end
      row_cnt = 0;
      col_cnt = 0;
      found   = 0;
      aborted = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COLUMNS:  columns_r = data[DIM_W-1:0];
        REG_ROWS:     rows_r    = data[DIM_W-1:0];
        REG_HALF:     half_r    = data[HALF_W-1:0];
        REG_MARGIN:   margin_r  = shortint'(data[NM_W-1:0]);
        REG_CAPACITY: cap_r     = data[CAP_W-1:0];
        REG_USE_MASK: mask_r    = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void push_hit(int unsigned col, int unsigned row, bit ovf);
      detection_t h;
      h.col  = col[COORD_W-1:0];
      h.row  = row[COORD_W-1:0];
      h.ovf  = ovf;
      h.last = 1'b0;
      pending_hits.push_back(h);
    endfunction

    // decide row d against the window clipped at the newest row cur
    function void decide_row(int unsigned d, int unsigned cur, int unsigned half);
      int unsigned lo, hi, k;
      longint      sum, cnt, lhs, rhs;
      if (aborted) return;
      lo  = (d + 1 >= half) ? d + 1 - half : 0;
      hi  = (d + half < cur) ? d + half : cur;
      sum = 0;
      for (k = lo; k <= hi; k++) sum += longint'(value_ring[k % RING_D]);
      cnt = hi - lo + 1;
      if (mask_r && !good_ring[d % RING_D]) return;
      lhs = longint'(value_ring[d % RING_D]) * cnt * 16;
      rhs = sum * 16 + longint'(margin_r) * cnt;
      if (lhs <= rhs) return;
      if (found >= cap_r) begin
        push_hit(0, 0, 1'b1);
        aborted = 1'b1;
        return;
      end
      push_hit(col_cnt, d, 1'b0);
      found++;
    endfunction

    function void note_pixel(bit [PIX_W-1:0] v, bit g);
      int unsigned half, rows_e, cols_e, r, d, start;
      bit          last_row;
      half   = (half_r == 0) ? 1 : half_r;
      rows_e = clamp_size(rows_r);
      cols_e = clamp_size(columns_r);
      r      = row_cnt;
      value_ring[r % RING_D] = v;
      good_ring[r % RING_D]  = g;
      start    = pending_hits.size();
      last_row = (r >= rows_e - 1);
      if (last_row) begin
        for (d = (r >= half) ? r - half : 0; d <= r; d++) decide_row(d, r, half);
      end else if (r >= half) begin
        decide_row(r - half, r, half);
      end
      if (pending_hits.size() > start) pending_hits[pending_hits.size() - 1].last = 1'b1;
      if (last_row) begin
        row_cnt = 0;
        if (col_cnt >= cols_e - 1) begin
          col_cnt = 0;
          found   = 0;
          aborted = 1'b0;
        end else begin
          col_cnt++;
        end
      end else begin
        row_cnt = r + 1;
      end
    endfunction

    task flag_mismatch(string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_detection(bit [COORD_W-1:0] col, bit [COORD_W-1:0] row, bit ovf, bit last);
      detection_t h;
      if (pending_hits.size() == 0) begin
        flag_mismatch($sformatf("unexpected result col %0d row %0d ovf %0d", col, row, ovf));
        return;
      end
      h = pending_hits.pop_front();
      if (col != h.col) flag_mismatch($sformatf("hit_column %0d, want %0d", col, h.col));
      if (row != h.row) flag_mismatch($sformatf("hit_row %0d, want %0d", row, h.row));
      if (ovf != h.ovf) flag_mismatch($sformatf("overflow %0d, want %0d", ovf, h.ovf));
      if (last != h.last) flag_mismatch($sformatf("tlast %0d, want %0d", last, h.last));
    endtask

    task check_drained();
      if (pending_hits.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", pending_hits.size()));
    endtask

    function int pending();
      return pending_hits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [2*COORD_W-1:0]  m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  detect_scoreboard sb = new();
  int idle_cycles = 0;

  column_boxcar_signal_detect dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel(int base);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 70) v = base + $urandom_range(0, 63);
    else if (r < 88) v = base + $urandom_range(500, 8000);
    else if (r < 97) v = $urandom_range(0, 65535);
    else if (r < 99) v = 0;
    else v = 65535;
    if (v > 65535) v = 65535;
    return v[PIX_W-1:0];
  endfunction

  // result side
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_detection(m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W], m_tuser[0], m_tlast);
  end

  initial begin
    int run, stall;
    @(negedge rst);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data[CFG_DATA_W-1:0]);
  endtask

  task automatic apply_settings(int cols, int rows, int half, int margin, int cap, int mask);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_put(REG_COLUMNS, cols);
    cfg_put(REG_ROWS, rows);
    cfg_put(REG_HALF, half);
    cfg_put(REG_MARGIN, margin & 16'hFFFF);
    cfg_put(REG_CAPACITY, cap);
    cfg_put(REG_USE_MASK, mask);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] v, logic g, int gap);
    s_tvalid   <= 1'b1;
    s_tdata    <= v;
    s_tuser[0] <= g;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(v, g);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_phase(int cols, int rows, int half, int margin, int cap, int mask,
                           int n);
    int base, i, gap;
    bit steady;
    apply_settings(cols, rows, half, margin, cap, mask);
    base   = $urandom_range(50, 2000);
    steady = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n; i++) begin
      gap = steady ? 0 : pick_gap();
      send_pixel(next_pixel(base), $urandom_range(0, 9) != 0, gap);
      // hold the source until all outstanding detections are out
      if (i % 47 == 23) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_results();
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    logic [PIX_W-1:0] dir_val [8];
    logic             dir_good [8];
    int i;
    dir_val  = '{16'd0, 16'd65535, 16'd10, 16'd10, 16'd65535, 16'd10, 16'd10, 16'd65535};
    dir_good = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // masked bad pixels, value extremes, frame end
    apply_settings(2, 4, 1, 16, CAP_TOP, 1);
    for (i = 0; i < 8; i++) send_pixel(dir_val[i], dir_good[i], pick_gap());
    s_tvalid <= 1'b0;

    // overflow with a capacity of one, then a fresh frame
    apply_settings(2, 4, 1, -32768, 1, 0);
    for (i = 0; i < 12; i++) send_pixel(PIX_W'(1000 + i), i[0], pick_gap());
    s_tvalid <= 1'b0;

    run_phase(3, 16, 2, 160, CAP_TOP, 0, 60);
    run_phase(0, 40, 31, -32768, CAP_TOP, 0, 50);
    run_phase(8191, 8191, 0, 32767, 0, 1, 40);
    run_phase(5, 7, 3, 0, 3, 1, 80);
    run_phase(2, 64, 20, -200, 10, 0, 60);
    run_phase(4096, 1, 5, -1, CAP_TOP, 1, 60);
    run_phase(1, 4096, 31, 32, CAP_TOP - 1, 0, 60);
    run_phase(6, 12, 4, -16, 5, 1, 60);

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
